// ===== rtl/qfn_pkg.sv =====
// ----------------------------------------------------------------------------
// qfn_pkg: shared types and constants of the quad face normal block
// word layouts of both channels, corner cross-product vector, queue depth
// ----------------------------------------------------------------------------
package qfn_pkg;

  // exact cross product of two 33-bit edges needs 67 signed bits
  localparam int CROSS_W = 67;
  // corner vectors wait here between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic signed [31:0] p0_x;
    logic signed [31:0] p0_y;
    logic signed [31:0] p0_z;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p1_z;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p2_z;
    logic signed [31:0] p3_x;
    logic signed [31:0] p3_y;
    logic signed [31:0] p3_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } out_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] x;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] z;
  } vec_t;

endpackage

// ===== rtl/qfn_front.sv =====
// ----------------------------------------------------------------------------
// qfn_front: corner cross products
// holds one quad and, unless stalled by the queue, emits one exact corner normal v x u per cycle
// ----------------------------------------------------------------------------
module qfn_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  qfn_pkg::in_t in_word_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output qfn_pkg::vec_t out_vec_o
);

  localparam int CW = qfn_pkg::CROSS_W;

  qfn_pkg::in_t       quad_q;
  logic               hold_q;
  logic [1:0]         cnt_q;
  logic               p_v_q;
  logic signed [65:0] prod_q [6];

  logic signed [31:0] cx, cy, cz, px, py, pz, nx, ny, nz;
  logic signed [32:0] ux, uy, uz, ax, ay, az;
  logic               p_adv, load;

  // point select by corner index
  function automatic logic signed [95:0] pt(qfn_pkg::in_t q, logic [1:0] idx);
    logic signed [95:0] r;
    case (idx)
      2'd0:    r = {q.p0_x, q.p0_y, q.p0_z};
      2'd1:    r = {q.p1_x, q.p1_y, q.p1_z};
      2'd2:    r = {q.p2_x, q.p2_y, q.p2_z};
      default: r = {q.p3_x, q.p3_y, q.p3_z};
    endcase
    return r;
  endfunction

  always_comb begin
    {cx, cy, cz} = pt(quad_q, cnt_q);
    {px, py, pz} = pt(quad_q, cnt_q - 2'd1);
    {nx, ny, nz} = pt(quad_q, cnt_q + 2'd1);
    ux = 33'(cx) - 33'(px);
    uy = 33'(cy) - 33'(py);
    uz = 33'(cz) - 33'(pz);
    ax = 33'(nx) - 33'(cx);
    ay = 33'(ny) - 33'(cy);
    az = 33'(nz) - 33'(cz);
  end

  assign p_adv      = !p_v_q || out_ready_i;
  assign load       = hold_q && p_adv;
  assign in_ready_o = !hold_q || (load && (cnt_q == 2'd3));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      cnt_q  <= 2'd0;
      p_v_q  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        hold_q <= 1'b1;
      end else if (load && (cnt_q == 2'd3)) begin
        hold_q <= 1'b0;
      end
      if (load) begin
        cnt_q <= cnt_q + 2'd1;
        p_v_q <= 1'b1;
      end else if (p_adv) begin
        p_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      quad_q <= in_word_i;
    end
    if (load) begin
      prod_q[0] <= ay * uz;
      prod_q[1] <= az * uy;
      prod_q[2] <= az * ux;
      prod_q[3] <= ax * uz;
      prod_q[4] <= ax * uy;
      prod_q[5] <= ay * ux;
    end
  end

  assign out_valid_o = p_v_q;
  assign out_vec_o.x = CW'(prod_q[0]) - CW'(prod_q[1]);
  assign out_vec_o.y = CW'(prod_q[2]) - CW'(prod_q[3]);
  assign out_vec_o.z = CW'(prod_q[4]) - CW'(prod_q[5]);

`ifndef NO_ASSERTIONS
  // a stalled product register keeps its corner
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_v_q && !out_ready_i) |=> (p_v_q && $stable(prod_q[0]) && $stable(cnt_q)))
    else $error("front product lost while stalled");
  // a quad is released only after its last corner
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q && !load) |=> hold_q)
    else $error("front released a quad early");
  // corner count returns to zero once a quad is done
  a_cnt_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hold_q |-> (cnt_q == 2'd0))
    else $error("corner count not aligned to quad");
`endif

endmodule

// ===== rtl/qfn_queue.sv =====
// ----------------------------------------------------------------------------
// qfn_queue: small fifo of corner vectors
// decouples the cross-product front from the shared normalizer
// ----------------------------------------------------------------------------
module qfn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  qfn_pkg::vec_t wr_vec_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output qfn_pkg::vec_t rd_vec_o
);

  localparam int PW = qfn_pkg::Q_PTR_W;

  qfn_pkg::vec_t mem_q [qfn_pkg::Q_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          wr, rd;

  assign wr_ready_o = (cnt_q != (PW+1)'(qfn_pkg::Q_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_vec_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) begin
        wp_q <= wp_q + 1'b1;
      end
      if (rd) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_vec_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(qfn_pkg::Q_DEPTH))
    else $error("queue overfilled");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != (PW+1)'(qfn_pkg::Q_DEPTH)) |-> (wp_q != rp_q))
    else $error("queue pointers out of step with count");
  a_empty_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wp_q == rp_q))
    else $error("empty queue with pointer gap");
`endif

endmodule

// ===== rtl/qfn_norm.sv =====
// ----------------------------------------------------------------------------
// qfn_norm: shared unit-length scaler
// prescale, sum of squares, bit-per-stage square root, bit-per-stage divides
// ----------------------------------------------------------------------------
module qfn_norm #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic                in_sum_i,
  input  qfn_pkg::vec_t       in_vec_i,
  output logic                out_valid_o,
  output logic                out_sum_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_z_o
);

  localparam int CW = qfn_pkg::CROSS_W;
  localparam int QW = NORMAL_FRAC_BITS + 1;   // quotient bits
  localparam int DW = 32 + QW;                // divider remainder bits
  localparam int RW = NORMAL_FRAC_BITS + 2;   // signed result

  typedef struct packed {
    logic            is_sum;
    logic [2:0]      neg;
    logic [2:0][30:0] m;
  } side_t;

  function automatic logic [6:0] bitlen(logic [CW-1:0] x);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < CW; i++) begin
      if (x[i]) begin
        n = 7'(i + 1);
      end
    end
    return n;
  endfunction

  // stage 1: sign and magnitude
  logic                 s1_v_q, s1_sum_q;
  logic [2:0]           s1_neg_q;
  logic [2:0][CW-1:0]   s1_mag_q;
  // stage 2: prescale shift
  logic                 s2_v_q, s2_sum_q;
  logic [2:0]           s2_neg_q;
  logic [2:0][CW-1:0]   s2_mag_q;
  logic [5:0]           s2_sh_q;
  // stage 3: prescaled magnitudes
  logic                 s3_v_q;
  side_t                s3_sd_q;
  // stage 4: squares
  logic                 s4_v_q;
  side_t                s4_sd_q;
  logic [2:0][61:0]     s4_sq_q;
  // sqrt pipe, entry 0 is the sum of squares
  logic                 r_v_q    [0:32];
  side_t                r_sd_q   [0:32];
  logic [63:0]          r_rem_q  [0:32];
  logic [31:0]          r_root_q [0:32];
  // divide pipe, entry 0 holds length and scaled magnitudes
  logic                 d_v_q    [0:QW];
  logic                 d_sum_q  [0:QW];
  logic [2:0]           d_neg_q  [0:QW];
  logic [31:0]          d_len_q  [0:QW];
  logic [2:0][DW-1:0]   d_rem_q  [0:QW];
  logic [2:0][QW-1:0]   d_quo_q  [0:QW];
  // result
  logic                 f_v_q, f_sum_q;
  logic signed [RW-1:0] f_res_q [3];

  logic [2:0][CW-1:0]   in_v;
  logic [6:0]           top;

  assign in_v = {in_vec_i.z, in_vec_i.y, in_vec_i.x};
  assign top  = bitlen(s1_mag_q[0] | s1_mag_q[1] | s1_mag_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      r_v_q[0] <= 1'b0;
      d_v_q[0] <= 1'b0;
      f_v_q  <= 1'b0;
    end else if (en_i) begin
      s1_v_q   <= in_valid_i;
      s2_v_q   <= s1_v_q;
      s3_v_q   <= s2_v_q;
      s4_v_q   <= s3_v_q;
      r_v_q[0] <= s4_v_q;
      d_v_q[0] <= r_v_q[32];
      f_v_q    <= d_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sum_q <= in_sum_i;
      for (int k = 0; k < 3; k++) begin
        s1_neg_q[k] <= in_v[k][CW-1];
        s1_mag_q[k] <= in_v[k][CW-1] ? CW'(-in_v[k]) : in_v[k];
      end
      s2_sum_q <= s1_sum_q;
      s2_neg_q <= s1_neg_q;
      s2_mag_q <= s1_mag_q;
      s2_sh_q  <= (top > 7'd31) ? 6'(top - 7'd31) : 6'd0;
      s3_sd_q.is_sum <= s2_sum_q;
      s3_sd_q.neg    <= s2_neg_q;
      for (int k = 0; k < 3; k++) begin
        s3_sd_q.m[k] <= 31'(s2_mag_q[k] >> s2_sh_q);
      end
      s4_sd_q <= s3_sd_q;
      for (int k = 0; k < 3; k++) begin
        s4_sq_q[k] <= 62'(s3_sd_q.m[k]) * 62'(s3_sd_q.m[k]);
      end
      r_sd_q[0]   <= s4_sd_q;
      r_rem_q[0]  <= 64'(s4_sq_q[0]) + 64'(s4_sq_q[1]) + 64'(s4_sq_q[2]);
      r_root_q[0] <= '0;
      d_sum_q[0]  <= r_sd_q[32].is_sum;
      d_neg_q[0]  <= r_sd_q[32].neg;
      d_len_q[0]  <= r_root_q[32];
      d_quo_q[0]  <= '0;
      for (int k = 0; k < 3; k++) begin
        d_rem_q[0][k] <= DW'(r_sd_q[32].m[k]) << NORMAL_FRAC_BITS;
      end
      f_sum_q <= d_sum_q[QW];
      for (int k = 0; k < 3; k++) begin
        if (d_len_q[QW] == '0) begin
          f_res_q[k] <= '0;
        end else if (d_neg_q[QW][k]) begin
          f_res_q[k] <= -RW'(d_quo_q[QW][k]);
        end else begin
          f_res_q[k] <= RW'(d_quo_q[QW][k]);
        end
      end
    end
  end

  // one root bit per stage
  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam int B = 31 - j;
    logic [65:0] trial;
    logic        take;
    assign trial = (66'(r_root_q[j]) << (B + 1)) + (66'd1 << (2 * B));
    assign take  = (66'(r_rem_q[j]) >= trial);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        r_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        r_v_q[j+1] <= r_v_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_sd_q[j+1]   <= r_sd_q[j];
        r_rem_q[j+1]  <= take ? 64'(66'(r_rem_q[j]) - trial) : r_rem_q[j];
        r_root_q[j+1] <= take ? (r_root_q[j] | (32'd1 << B)) : r_root_q[j];
      end
    end
  end

  // one quotient bit per stage, three lanes
  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam int B = NORMAL_FRAC_BITS - i;
    logic [DW-1:0] dvs;
    assign dvs = DW'(d_len_q[i]) << B;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        d_v_q[i+1] <= d_v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_sum_q[i+1] <= d_sum_q[i];
        d_neg_q[i+1] <= d_neg_q[i];
        d_len_q[i+1] <= d_len_q[i];
        for (int k = 0; k < 3; k++) begin
          if (d_rem_q[i][k] >= dvs) begin
            d_rem_q[i+1][k] <= d_rem_q[i][k] - dvs;
            d_quo_q[i+1][k] <= d_quo_q[i][k] | (QW'(1) << B);
          end else begin
            d_rem_q[i+1][k] <= d_rem_q[i][k];
            d_quo_q[i+1][k] <= d_quo_q[i][k];
          end
        end
      end
    end
  end

  assign out_valid_o = f_v_q;
  assign out_sum_o   = f_sum_q;
  assign out_x_o     = f_res_q[0];
  assign out_y_o     = f_res_q[1];
  assign out_z_o     = f_res_q[2];

`ifndef NO_ASSERTIONS
  // a frozen pipe keeps its tail
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(f_v_q) && $stable(s1_v_q)))
    else $error("normalizer moved while frozen");
  // a nonzero remainder after the last root stage comes with a nonzero root
  a_root_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_v_q[32] && r_rem_q[32] != '0) |-> (r_root_q[32] != '0))
    else $error("square root remainder without root");
  // prescaled magnitudes stay within 31 bits
  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (s2_sh_q <= 6'd36))
    else $error("prescale shift out of range");
`endif

endmodule

// ===== rtl/quad_face_normal_top.sv =====
// ----------------------------------------------------------------------------
// quad_face_normal_top: unit face normal of a quad
// normalizer: one shared slot, used by four corner normals and one face sum per quad
// reset: asynchronous, clears all valid and sequencing state, no clearing pass
// ----------------------------------------------------------------------------
module quad_face_normal_top #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qfn_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qfn_pkg::out_t out_word_o
);

  localparam int CW = qfn_pkg::CROSS_W;
  localparam int RW = NORMAL_FRAC_BITS + 2;  // one scaled component
  localparam int AW = NORMAL_FRAC_BITS + 4;  // sum of four components

  // front to queue
  logic          f_valid, f_ready;
  qfn_pkg::vec_t f_vec;
  // queue to back
  logic          q_valid, q_pop;
  qfn_pkg::vec_t q_vec;
  // normalizer
  logic          adv;
  logic          n_in_valid, n_in_sum;
  qfn_pkg::vec_t n_in_vec;
  logic          n_valid, n_sum;
  logic signed [RW-1:0] n_res [3];

  // back side state
  logic signed [AW-1:0] acc_q [3];
  logic [1:0]           corner_q;
  logic                 sum_v_q;
  qfn_pkg::vec_t        sum_q;
  logic                 out_v_q;
  qfn_pkg::out_t        out_q;

  logic signed [AW-1:0] acc_nx [3];

  // front: holds the quad and makes one corner cross product a cycle while the queue takes them
  qfn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_vec_o   (f_vec)
  );

  // corner vectors wait here for a normalizer slot
  qfn_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_vec_i   (f_vec),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_pop),
    .rd_vec_o   (q_vec)
  );

  // whole back pipe moves only while the output word can be taken
  assign adv = !out_v_q || out_ready_i;

  // a pending face sum has the slot over the next corner
  assign q_pop      = adv && !sum_v_q;
  assign n_in_valid = sum_v_q || q_valid;
  assign n_in_sum   = sum_v_q;
  assign n_in_vec   = sum_v_q ? sum_q : q_vec;

  qfn_norm #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .in_valid_i  (n_in_valid),
    .in_sum_i    (n_in_sum),
    .in_vec_i    (n_in_vec),
    .out_valid_o (n_valid),
    .out_sum_o   (n_sum),
    .out_x_o     (n_res[0]),
    .out_y_o     (n_res[1]),
    .out_z_o     (n_res[2])
  );

  // clamp to the 16-bit output range
  function automatic logic signed [15:0] sat16(logic signed [RW-1:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    if (w > 32'sd32767) begin
      return 16'sh7fff;
    end else if (w < -32'sd32768) begin
      return 16'sh8000;
    end
    return 16'(w);
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_nx[k] = acc_q[k] + AW'(n_res[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= 2'd0;
      sum_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= '0;
      end
    end else begin
      if (adv && n_valid && !n_sum) begin
        corner_q <= corner_q + 2'd1;
        for (int k = 0; k < 3; k++) begin
          acc_q[k] <= (corner_q == 2'd3) ? '0 : acc_nx[k];
        end
      end
      // last corner of a face arms the sum, the next slot takes it
      if (adv && n_valid && !n_sum && (corner_q == 2'd3)) begin
        sum_v_q <= 1'b1;
      end else if (adv) begin
        sum_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= n_valid && n_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && n_valid && !n_sum && (corner_q == 2'd3)) begin
      sum_q.x <= CW'(acc_nx[0]);
      sum_q.y <= CW'(acc_nx[1]);
      sum_q.z <= CW'(acc_nx[2]);
    end
    if (adv && n_valid && n_sum) begin
      out_q.normal_x <= sat16(n_res[0]);
      out_q.normal_y <= sat16(n_res[1]);
      out_q.normal_z <= sat16(n_res[2]);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

`ifndef NO_ASSERTIONS
  // queue is never drained in a slot given to a face sum
  a_sum_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_valid) |-> !sum_v_q)
    else $error("corner issued over a pending face sum");
  // a face sum enters the normalizer in the first slot after it is armed
  a_sum_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && sum_v_q) |=> !sum_v_q)
    else $error("face sum held past its slot");
  // a waiting output word stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && $stable(out_q)))
    else $error("output word changed while stalled");
`endif

endmodule
